[design/rrfp_pkg.sv]
// ----------------------------------------------------------------------------
// rrfp_pkg
// Shared types and codes for the reader response frame parser.
// ----------------------------------------------------------------------------
package rrfp_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned EVENT_W    = 3;
  localparam int unsigned PINDEX_W   = 4;
  localparam int unsigned PCOUNT_W   = 5;
  localparam int unsigned IN_TDATA_W = 8;
  localparam int unsigned OUT_TUSER_W = 4;
  localparam int unsigned OUT_TDATA_W = 32;

  // framing bytes
  localparam logic [7:0] STX = 8'h02;
  localparam logic [7:0] ETX = 8'h03;

  // reply command codes
  localparam logic [7:0] CMD_READ_CARD = 8'hA0;
  localparam logic [7:0] CMD_READ_DATA = 8'hA1;
  localparam logic [7:0] CMD_WRITE_A   = 8'hA2;
  localparam logic [7:0] CMD_WRITE_B   = 8'hA3;
  localparam logic [7:0] CMD_CARD_A    = 8'hA6;
  localparam logic [7:0] CMD_CARD_B    = 8'hA7;
  localparam logic [7:0] CMD_BEEP_A    = 8'hA8;
  localparam logic [7:0] CMD_BEEP_B    = 8'hA9;

  localparam logic [7:0] FAIL_LEN    = 8'd7;
  localparam logic [7:0] STATUS_OK   = 8'h00;
  localparam logic [7:0] STATUS_ALT  = 8'h06;
  localparam logic [4:0] CARD_BYTES  = 5'd4;
  localparam logic [4:0] DATA_BYTES  = 5'd16;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_OK         = 3'd1,
    EV_INVALID    = 3'd2,
    EV_CHECK_FAIL = 3'd3,
    EV_LEN_ERR    = 3'd4
  } event_t;

  typedef enum logic [3:0] {
    PH_HUNT,
    PH_LEN,
    PH_CMD,
    PH_CARD,
    PH_CARD_ZERO,
    PH_DATA,
    PH_DATA_BLOCK,
    PH_STATUS,
    PH_BLOCK,
    PH_DROP,
    PH_CHECK,
    PH_END
  } phase_t;

  typedef struct packed {
    event_t                event_res;
    logic                  payload_valid;
    logic [PINDEX_W-1:0]   payload_index;
    logic [BYTE_W-1:0]     payload_byte;
    logic [BYTE_W-1:0]     frame_command;
    logic                  frame_success;
    logic [BYTE_W-1:0]     block_number;
  } rrfp_res_t;

endpackage

[design/reader_response_frame_parser_core.sv]
// ----------------------------------------------------------------------------
// reader_response_frame_parser_core
// STX/ETX reply frame parser with XOR check for a tag reader link.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side: one received link byte per beat on in_tdata[7:0].
//   Master side: one result beat for every input beat. out_tuser carries the
//   event code and the payload flag; out_tdata carries the payload index and
//   byte, the frame command, the success flag and the block number.
//   The result of a byte sits in the output register the cycle after the
//   byte is taken. Throughput is one byte per cycle while the master side
//   drains, set by the single frame state update before the result register.
//   in_tready drops only while a result waits and out_tready is low; the
//   output register refills in the same cycle it is drained, so a stall on
//   the master side holds the input side for exactly as long.
//   Reset (rst_n low, synchronous) puts the parser into hunting for STX and
//   empties the output register.
//   Errors report an event and return the parser to hunting; a bad ETX and
//   beep replies that are not failure frames end without an event.
// ----------------------------------------------------------------------------
module reader_response_frame_parser_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [rrfp_pkg::IN_TDATA_W-1:0]       in_tdata,   // [7:0] rx_byte
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [2:0] event_res, [3] payload_valid
  output logic [rrfp_pkg::OUT_TUSER_W-1:0]      out_tuser,
  // [3:0] payload_index, [11:4] payload_byte, [19:12] frame_command,
  // [20] frame_success, [28:21] block_number, [31:29] zero
  output logic [rrfp_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  logic                in_beat;
  rrfp_pkg::rrfp_res_t res;

  assign in_beat = in_tvalid && in_tready;

  rrfp_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (in_beat),
    .byte_in  (in_tdata),
    .res      (res)
  );

  rrfp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_beat),
    .res        (res),
    .ready      (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  // every accepted byte produces a result beat next cycle
  a_beat_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> out_tvalid)
    else $error("accepted byte produced no result");

  // a payload beat never carries an event
  a_payload_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[3]) |-> (out_tuser[2:0] == rrfp_pkg::EV_NONE))
    else $error("payload beat with event");

  // frame fields are zero unless the frame completed
  a_frame_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser[2:0] != rrfp_pkg::EV_OK)) |->
      (out_tdata[28:12] == 17'd0))
    else $error("frame fields set without completed frame");

  // event codes stay within the defined range
  a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[2:0] <= rrfp_pkg::EV_LEN_ERR))
    else $error("event code out of range");

endmodule

[design/rrfp_parser.sv]
// ----------------------------------------------------------------------------
// rrfp_parser
// Frame state machine and running XOR/count; forms the result of each byte.
// ----------------------------------------------------------------------------
module rrfp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_vld,
  input  logic [7:0]        byte_in,
  output rrfp_pkg::rrfp_res_t res
);

  rrfp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] seen_r, seen_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] stat_r, stat_nxt;
  logic [7:0] blk_r, blk_nxt;
  logic [rrfp_pkg::PCOUNT_W-1:0] pcnt_r, pcnt_nxt;

  logic [7:0] xor_take;
  logic [7:0] seen_take;
  logic [rrfp_pkg::PCOUNT_W-1:0] pcnt_inc;
  logic       fail_len;
  logic       len_ok;

  assign xor_take  = xor_r ^ byte_in;
  assign seen_take = seen_r + 8'd1;
  assign pcnt_inc  = pcnt_r + 5'd1;
  assign fail_len  = (len_r == rrfp_pkg::FAIL_LEN);
  // count wraps at 8 bits, compare is 9 bits wide
  assign len_ok    = (({1'b0, seen_take} + 9'd1) == {1'b0, len_r});

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      rrfp_pkg::PH_HUNT: begin
        phase_nxt = (byte_in == rrfp_pkg::STX) ? rrfp_pkg::PH_LEN : rrfp_pkg::PH_HUNT;
      end
      rrfp_pkg::PH_LEN: phase_nxt = rrfp_pkg::PH_CMD;
      rrfp_pkg::PH_CMD: begin
        unique case (byte_in)
          rrfp_pkg::CMD_READ_CARD, rrfp_pkg::CMD_CARD_A, rrfp_pkg::CMD_CARD_B:
            phase_nxt = fail_len ? rrfp_pkg::PH_STATUS : rrfp_pkg::PH_CARD;
          rrfp_pkg::CMD_READ_DATA:
            phase_nxt = fail_len ? rrfp_pkg::PH_STATUS : rrfp_pkg::PH_DATA;
          rrfp_pkg::CMD_WRITE_A, rrfp_pkg::CMD_WRITE_B:
            phase_nxt = rrfp_pkg::PH_STATUS;
          rrfp_pkg::CMD_BEEP_A, rrfp_pkg::CMD_BEEP_B:
            phase_nxt = fail_len ? rrfp_pkg::PH_STATUS : rrfp_pkg::PH_DROP;
          default:
            phase_nxt = rrfp_pkg::PH_HUNT;
        endcase
      end
      rrfp_pkg::PH_CARD: begin
        if (pcnt_inc == rrfp_pkg::CARD_BYTES) phase_nxt = rrfp_pkg::PH_CARD_ZERO;
      end
      rrfp_pkg::PH_DATA: begin
        if (pcnt_inc == rrfp_pkg::DATA_BYTES) phase_nxt = rrfp_pkg::PH_DATA_BLOCK;
      end
      rrfp_pkg::PH_CARD_ZERO: begin
        phase_nxt = (byte_in == 8'd0) ? rrfp_pkg::PH_CHECK : rrfp_pkg::PH_HUNT;
      end
      rrfp_pkg::PH_DATA_BLOCK, rrfp_pkg::PH_BLOCK: phase_nxt = rrfp_pkg::PH_CHECK;
      rrfp_pkg::PH_STATUS: phase_nxt = rrfp_pkg::PH_BLOCK;
      rrfp_pkg::PH_CHECK: begin
        phase_nxt = (len_ok && (xor_take == 8'd0)) ? rrfp_pkg::PH_END : rrfp_pkg::PH_HUNT;
      end
      default: phase_nxt = rrfp_pkg::PH_HUNT;
    endcase
  end

  // frame fields
  always_comb begin
    xor_nxt  = xor_r;
    seen_nxt = seen_r;
    len_nxt  = len_r;
    cmd_nxt  = cmd_r;
    stat_nxt = stat_r;
    blk_nxt  = blk_r;
    pcnt_nxt = pcnt_r;
    unique case (phase_r)
      rrfp_pkg::PH_HUNT: begin
        xor_nxt  = 8'd0;
        seen_nxt = 8'd1;
        len_nxt  = 8'd0;
        cmd_nxt  = 8'd0;
        stat_nxt = 8'd0;
        blk_nxt  = 8'd0;
        pcnt_nxt = '0;
      end
      rrfp_pkg::PH_LEN: begin
        len_nxt  = byte_in;
        xor_nxt  = xor_take;
        seen_nxt = seen_take;
      end
      rrfp_pkg::PH_CMD: begin
        cmd_nxt  = byte_in;
        xor_nxt  = xor_take;
        seen_nxt = seen_take;
        pcnt_nxt = '0;
      end
      rrfp_pkg::PH_CARD, rrfp_pkg::PH_DATA: begin
        xor_nxt  = xor_take;
        seen_nxt = seen_take;
        pcnt_nxt = pcnt_inc;
      end
      rrfp_pkg::PH_DATA_BLOCK, rrfp_pkg::PH_BLOCK: begin
        blk_nxt  = byte_in;
        xor_nxt  = xor_take;
        seen_nxt = seen_take;
      end
      rrfp_pkg::PH_STATUS: begin
        stat_nxt = byte_in;
        xor_nxt  = xor_take;
        seen_nxt = seen_take;
      end
      rrfp_pkg::PH_CARD_ZERO, rrfp_pkg::PH_CHECK: begin
        xor_nxt  = xor_take;
        seen_nxt = seen_take;
      end
      default: begin
        // drop, end: nothing taken
      end
    endcase
  end

  // result of the current byte
  always_comb begin
    res = '0;
    unique case (phase_r)
      rrfp_pkg::PH_CMD: begin
        unique case (byte_in)
          rrfp_pkg::CMD_READ_CARD, rrfp_pkg::CMD_CARD_A, rrfp_pkg::CMD_CARD_B,
          rrfp_pkg::CMD_READ_DATA, rrfp_pkg::CMD_WRITE_A, rrfp_pkg::CMD_WRITE_B,
          rrfp_pkg::CMD_BEEP_A, rrfp_pkg::CMD_BEEP_B:
            res.event_res = rrfp_pkg::EV_NONE;
          default:
            res.event_res = rrfp_pkg::EV_INVALID;
        endcase
      end
      rrfp_pkg::PH_CARD, rrfp_pkg::PH_DATA: begin
        res.payload_valid = 1'b1;
        res.payload_index = pcnt_r[rrfp_pkg::PINDEX_W-1:0];
        res.payload_byte  = byte_in;
      end
      rrfp_pkg::PH_CARD_ZERO: begin
        if (byte_in != 8'd0) res.event_res = rrfp_pkg::EV_INVALID;
      end
      rrfp_pkg::PH_CHECK: begin
        // length is checked ahead of the XOR
        if (!len_ok)                res.event_res = rrfp_pkg::EV_LEN_ERR;
        else if (xor_take != 8'd0)  res.event_res = rrfp_pkg::EV_CHECK_FAIL;
      end
      rrfp_pkg::PH_END: begin
        if (byte_in == rrfp_pkg::ETX) begin
          res.event_res     = rrfp_pkg::EV_OK;
          res.frame_command = cmd_r;
          res.frame_success = (stat_r == rrfp_pkg::STATUS_OK) ||
                              (stat_r == rrfp_pkg::STATUS_ALT);
          res.block_number  = blk_r;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rrfp_pkg::PH_HUNT;
      xor_r   <= 8'd0;
      seen_r  <= 8'd0;
      len_r   <= 8'd0;
      cmd_r   <= 8'd0;
      stat_r  <= 8'd0;
      blk_r   <= 8'd0;
      pcnt_r  <= '0;
    end else if (byte_vld) begin
      phase_r <= phase_nxt;
      xor_r   <= xor_nxt;
      seen_r  <= seen_nxt;
      len_r   <= len_nxt;
      cmd_r   <= cmd_nxt;
      stat_r  <= stat_nxt;
      blk_r   <= blk_nxt;
      pcnt_r  <= pcnt_nxt;
    end
  end

endmodule

[design/rrfp_out_stage.sv]
// ----------------------------------------------------------------------------
// rrfp_out_stage
// Result register on the master side; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module rrfp_out_stage (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  load,
  input  rrfp_pkg::rrfp_res_t                   res,
  output logic                                  ready,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [rrfp_pkg::OUT_TUSER_W-1:0]      out_tuser,
  output logic [rrfp_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  logic                valid_r, valid_nxt;
  rrfp_pkg::rrfp_res_t res_r;

  assign ready     = !valid_r || out_tready;
  assign valid_nxt = load || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = {res_r.payload_valid, res_r.event_res};
  assign out_tdata  = {3'd0, res_r.block_number, res_r.frame_success,
                       res_r.frame_command, res_r.payload_byte, res_r.payload_index};

endmodule

[tb/rrfp_reply_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rrfp_reply_checker
// Watches both streams of the frame parser, predicts one result beat per
// accepted byte and compares every result beat field by field.
// ----------------------------------------------------------------------------
module rrfp_reply_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [rrfp_pkg::IN_TDATA_W-1:0]  in_tdata,    // [7:0] rx_byte
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // [2:0] event_res, [3] payload_valid
  input  logic [rrfp_pkg::OUT_TUSER_W-1:0] out_tuser,
  // [3:0] payload_index, [11:4] payload_byte, [19:12] frame_command,
  // [20] frame_success, [28:21] block_number, [31:29] zero
  input  logic [rrfp_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                               fail_count,
  output int                               pending
);

  localparam int unsigned MAX_PRINTS = 200;

  // predicted parser state
  rrfp_pkg::phase_t fr_phase;
  logic [7:0]  fr_xor;
  logic [7:0]  fr_count;
  logic [7:0]  fr_len;
  logic [7:0]  fr_cmd;
  logic [7:0]  fr_status;
  logic [7:0]  fr_block;
  logic [4:0]  fr_pay;

  rrfp_pkg::rrfp_res_t frame_results_q[$];
  int          mismatches;
  int          beat_no;

  initial begin
    mismatches = 0;
    beat_no    = 0;
  end

  task automatic clear_frame();
    fr_xor    = '0;
    fr_count  = '0;
    fr_len    = '0;
    fr_cmd    = '0;
    fr_status = '0;
    fr_block  = '0;
    fr_pay    = '0;
  endtask

  task automatic absorb(input logic [7:0] b);
    fr_xor   = fr_xor ^ b;
    fr_count = fr_count + 8'd1;
  endtask

  task automatic parse_reply_byte(input logic [7:0] b, output rrfp_pkg::rrfp_res_t r);
    logic fail_reply;
    r = '0;
    case (fr_phase)
      rrfp_pkg::PH_HUNT: begin
        clear_frame();
        fr_count = 8'd1;
        if (b == rrfp_pkg::STX) fr_phase = rrfp_pkg::PH_LEN;
      end
      rrfp_pkg::PH_LEN: begin
        fr_len = b;
        absorb(b);
        fr_phase = rrfp_pkg::PH_CMD;
      end
      rrfp_pkg::PH_CMD: begin
        fr_cmd = b;
        absorb(b);
        fr_pay = '0;
        fail_reply = (fr_len == rrfp_pkg::FAIL_LEN);
        case (b)
          rrfp_pkg::CMD_READ_CARD, rrfp_pkg::CMD_CARD_A, rrfp_pkg::CMD_CARD_B:
            fr_phase = fail_reply ? rrfp_pkg::PH_STATUS : rrfp_pkg::PH_CARD;
          rrfp_pkg::CMD_READ_DATA:
            fr_phase = fail_reply ? rrfp_pkg::PH_STATUS : rrfp_pkg::PH_DATA;
          rrfp_pkg::CMD_WRITE_A, rrfp_pkg::CMD_WRITE_B:
            fr_phase = rrfp_pkg::PH_STATUS;
          rrfp_pkg::CMD_BEEP_A, rrfp_pkg::CMD_BEEP_B:
            fr_phase = fail_reply ? rrfp_pkg::PH_STATUS : rrfp_pkg::PH_DROP;
          default: begin
            r.event_res = rrfp_pkg::EV_INVALID;
            fr_phase = rrfp_pkg::PH_HUNT;
          end
        endcase
      end
      rrfp_pkg::PH_CARD, rrfp_pkg::PH_DATA: begin
        r.payload_valid = 1'b1;
        r.payload_index = fr_pay[3:0];
        r.payload_byte  = b;
        absorb(b);
        fr_pay = fr_pay + 5'd1;
        if (fr_phase == rrfp_pkg::PH_CARD && fr_pay == rrfp_pkg::CARD_BYTES)
          fr_phase = rrfp_pkg::PH_CARD_ZERO;
        else if (fr_phase == rrfp_pkg::PH_DATA && fr_pay == rrfp_pkg::DATA_BYTES)
          fr_phase = rrfp_pkg::PH_DATA_BLOCK;
      end
      rrfp_pkg::PH_CARD_ZERO: begin
        absorb(b);
        if (b == 8'h00) begin
          fr_phase = rrfp_pkg::PH_CHECK;
        end else begin
          r.event_res = rrfp_pkg::EV_INVALID;
          fr_phase = rrfp_pkg::PH_HUNT;
        end
      end
      rrfp_pkg::PH_DATA_BLOCK, rrfp_pkg::PH_BLOCK: begin
        fr_block = b;
        absorb(b);
        fr_phase = rrfp_pkg::PH_CHECK;
      end
      rrfp_pkg::PH_STATUS: begin
        fr_status = b;
        absorb(b);
        fr_phase = rrfp_pkg::PH_BLOCK;
      end
      rrfp_pkg::PH_CHECK: begin
        absorb(b);
        // length is judged before the xor
        if ({1'b0, fr_count} + 9'd1 == {1'b0, fr_len}) begin
          if (fr_xor == 8'h00) begin
            fr_phase = rrfp_pkg::PH_END;
          end else begin
            r.event_res = rrfp_pkg::EV_CHECK_FAIL;
            fr_phase = rrfp_pkg::PH_HUNT;
          end
        end else begin
          r.event_res = rrfp_pkg::EV_LEN_ERR;
          fr_phase = rrfp_pkg::PH_HUNT;
        end
      end
      rrfp_pkg::PH_END: begin
        if (b == rrfp_pkg::ETX) begin
          r.event_res     = rrfp_pkg::EV_OK;
          r.frame_command = fr_cmd;
          r.frame_success = (fr_status == rrfp_pkg::STATUS_OK ||
                             fr_status == rrfp_pkg::STATUS_ALT);
          r.block_number  = fr_block;
        end
        fr_phase = rrfp_pkg::PH_HUNT;
      end
      // beep replies that are not failures swallow one byte
      default: fr_phase = rrfp_pkg::PH_HUNT;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch at result beat %0d: %s got 0x%0h want 0x%0h",
               beat_no, what, got, want);
  endtask

  always @(posedge clk) begin : watch
    rrfp_pkg::rrfp_res_t want;
    rrfp_pkg::rrfp_res_t pred;
    if (!rst_n) begin
      clear_frame();
      fr_phase = rrfp_pkg::PH_HUNT;
      frame_results_q.delete();
    end else begin
      // drain first: a result never leaves in the cycle its byte enters
      if (out_tvalid && out_tready) begin
        if (frame_results_q.size() == 0) begin
          report_mismatch("unexpected result beat", {out_tuser, out_tdata[27:0]}, 32'd0);
        end else begin
          want = frame_results_q.pop_front();
          if (out_tuser[2:0] != want.event_res)
            report_mismatch("event_res", 32'(out_tuser[2:0]), 32'(want.event_res));
          if (out_tuser[3] != want.payload_valid)
            report_mismatch("payload_valid", 32'(out_tuser[3]), 32'(want.payload_valid));
          if (out_tdata[3:0] != want.payload_index)
            report_mismatch("payload_index", 32'(out_tdata[3:0]), 32'(want.payload_index));
          if (out_tdata[11:4] != want.payload_byte)
            report_mismatch("payload_byte", 32'(out_tdata[11:4]), 32'(want.payload_byte));
          if (out_tdata[19:12] != want.frame_command)
            report_mismatch("frame_command", 32'(out_tdata[19:12]),
                            32'(want.frame_command));
          if (out_tdata[20] != want.frame_success)
            report_mismatch("frame_success", 32'(out_tdata[20]), 32'(want.frame_success));
          if (out_tdata[28:21] != want.block_number)
            report_mismatch("block_number", 32'(out_tdata[28:21]), 32'(want.block_number));
          if (out_tdata[31:29] != 3'd0)
            report_mismatch("tdata pad", 32'(out_tdata[31:29]), 32'd0);
        end
        beat_no++;
      end
      if (in_tvalid && in_tready) begin
        parse_reply_byte(in_tdata[7:0], pred);
        frame_results_q.push_back(pred);
      end
    end
    pending    <= frame_results_q.size();
    fail_count <= mismatches;
  end

endmodule

[tb/reader_response_frame_parser_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reader_response_frame_parser_core_tb
// Feeds reply frames, broken frames and line noise into the parser with
// random gaps and output stalls; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module reader_response_frame_parser_core_tb;

  typedef enum {
    FLAW_NONE,
    FLAW_XOR,
    FLAW_LEN,
    FLAW_BOTH,
    FLAW_ETX,
    FLAW_ZERO,
    FLAW_CUT,
    FLAW_LEN0
  } flaw_t;

  localparam int unsigned FRAME_BYTES_TARGET = 450;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [rrfp_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [rrfp_pkg::OUT_TUSER_W-1:0] out_tuser;
  logic [rrfp_pkg::OUT_TDATA_W-1:0] out_tdata;

  int fail_count;
  int pending;

  bit source_calm = 1'b0;
  bit sink_calm   = 1'b0;
  int stall_left  = 0;
  int frame_bytes = 0;

  logic [7:0] cmd_set[8] = '{rrfp_pkg::CMD_READ_CARD, rrfp_pkg::CMD_READ_DATA,
                             rrfp_pkg::CMD_WRITE_A, rrfp_pkg::CMD_WRITE_B,
                             rrfp_pkg::CMD_CARD_A, rrfp_pkg::CMD_CARD_B,
                             rrfp_pkg::CMD_BEEP_A, rrfp_pkg::CMD_BEEP_B};

  always #5 clk = ~clk;

  reader_response_frame_parser_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  rrfp_reply_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 9);
    else return $urandom_range(20, 50);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) sink_calm <= ~sink_calm;
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if (!sink_calm && $urandom_range(0, 99) < 25) stall_left <= pick_gap();
    end
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    int g;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    frame_bytes++;
    if (!source_calm && $urandom_range(0, 3) == 0) begin
      g = pick_gap();
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_frame(input logic [7:0] cmd, input bit fail_reply,
                            input logic [7:0] status, input flaw_t flaw);
    logic [7:0] pay[$];
    logic [7:0] wire_q[$];
    logic [7:0] len;
    logic [7:0] chk_byte;
    bit         card_lay;
    bit         data_lay;
    bit         beep_drop;
    bit         known;
    int         keep;
    card_lay  = (cmd == rrfp_pkg::CMD_READ_CARD || cmd == rrfp_pkg::CMD_CARD_A ||
                 cmd == rrfp_pkg::CMD_CARD_B) && !fail_reply;
    data_lay  = (cmd == rrfp_pkg::CMD_READ_DATA) && !fail_reply;
    beep_drop = (cmd == rrfp_pkg::CMD_BEEP_A || cmd == rrfp_pkg::CMD_BEEP_B) && !fail_reply;
    known     = 1'b0;
    foreach (cmd_set[i]) if (cmd_set[i] == cmd) known = 1'b1;
    if (card_lay) begin
      repeat (4) pay.push_back(8'($urandom_range(0, 255)));
      pay.push_back(flaw == FLAW_ZERO ? 8'($urandom_range(1, 255)) : 8'h00);
    end else if (data_lay) begin
      repeat (17) pay.push_back(8'($urandom_range(0, 255)));
    end else if (beep_drop || !known) begin
      repeat ($urandom_range(1, 3)) pay.push_back(8'($urandom_range(0, 255)));
    end else begin
      // status layout: status then block number; its length is the failure length
      pay.push_back(status);
      pay.push_back(8'($urandom_range(0, 255)));
    end
    len = 8'(5 + pay.size());
    if (flaw == FLAW_LEN || flaw == FLAW_BOTH) len = len + 8'($urandom_range(1, 255));
    if (flaw == FLAW_LEN0) len = 8'h00;
    chk_byte = len ^ cmd;
    foreach (pay[i]) chk_byte = chk_byte ^ pay[i];
    if (flaw == FLAW_XOR || flaw == FLAW_BOTH) chk_byte = chk_byte ^ 8'($urandom_range(1, 255));
    wire_q.push_back(rrfp_pkg::STX);
    wire_q.push_back(len);
    wire_q.push_back(cmd);
    foreach (pay[i]) wire_q.push_back(pay[i]);
    wire_q.push_back(chk_byte);
    wire_q.push_back(flaw == FLAW_ETX ? 8'($urandom_range(4, 255)) : rrfp_pkg::ETX);
    keep = (flaw == FLAW_CUT) ? int'($urandom_range(1, wire_q.size() - 1)) : wire_q.size();
    for (int i = 0; i < keep; i++) begin
      send_byte(wire_q[i]);
    end
  endtask

  function automatic logic [7:0] pick_status();
    int r;
    r = $urandom_range(0, 2);
    if (r == 0) return rrfp_pkg::STATUS_OK;
    else if (r == 1) return rrfp_pkg::STATUS_ALT;
    else return 8'($urandom_range(0, 255));
  endfunction

  initial begin : stimulus
    int   r;
    flaw_t fl;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every command, failure replies, each broken-frame case but the cut
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(rrfp_pkg::CMD_READ_CARD, 1'b0, rrfp_pkg::STATUS_OK, FLAW_NONE);
    send_frame(rrfp_pkg::CMD_READ_DATA, 1'b0, rrfp_pkg::STATUS_OK, FLAW_NONE);
    send_frame(rrfp_pkg::CMD_WRITE_A, 1'b0, rrfp_pkg::STATUS_OK, FLAW_NONE);
    send_frame(rrfp_pkg::CMD_WRITE_B, 1'b0, rrfp_pkg::STATUS_ALT, FLAW_NONE);
    send_frame(rrfp_pkg::CMD_WRITE_A, 1'b0, 8'hFF, FLAW_NONE);
    send_frame(rrfp_pkg::CMD_CARD_A, 1'b0, rrfp_pkg::STATUS_OK, FLAW_NONE);
    send_frame(rrfp_pkg::CMD_CARD_B, 1'b0, rrfp_pkg::STATUS_OK, FLAW_NONE);
    send_frame(rrfp_pkg::CMD_BEEP_A, 1'b0, rrfp_pkg::STATUS_OK, FLAW_NONE);
    send_frame(rrfp_pkg::CMD_BEEP_B, 1'b1, 8'h01, FLAW_NONE);
    send_frame(rrfp_pkg::CMD_READ_CARD, 1'b1, rrfp_pkg::STATUS_ALT, FLAW_NONE);
    send_frame(rrfp_pkg::CMD_READ_DATA, 1'b1, 8'h80, FLAW_NONE);
    send_frame(8'h00, 1'b0, rrfp_pkg::STATUS_OK, FLAW_NONE);
    send_frame(8'hFF, 1'b0, rrfp_pkg::STATUS_OK, FLAW_NONE);
    send_frame(rrfp_pkg::CMD_READ_CARD, 1'b0, rrfp_pkg::STATUS_OK, FLAW_ZERO);
    send_frame(rrfp_pkg::CMD_WRITE_B, 1'b0, rrfp_pkg::STATUS_OK, FLAW_XOR);
    send_frame(rrfp_pkg::CMD_READ_DATA, 1'b0, rrfp_pkg::STATUS_OK, FLAW_LEN);
    send_frame(rrfp_pkg::CMD_CARD_A, 1'b0, rrfp_pkg::STATUS_OK, FLAW_BOTH);
    send_frame(rrfp_pkg::CMD_WRITE_A, 1'b0, rrfp_pkg::STATUS_OK, FLAW_LEN0);
    send_frame(rrfp_pkg::CMD_CARD_B, 1'b0, rrfp_pkg::STATUS_OK, FLAW_ETX);
    drain_results();

    while (frame_bytes < FRAME_BYTES_TARGET) begin
      r = $urandom_range(0, 99);
      source_calm = ($urandom_range(0, 4) == 0);
      if (r < 10) begin
        send_noise($urandom_range(1, 5));
      end else if (r < 75) begin
        send_frame(cmd_set[$urandom_range(0, 7)], $urandom_range(0, 4) == 0,
                   pick_status(), FLAW_NONE);
      end else if (r < 80) begin
        send_frame(8'($urandom_range(0, 255)), 1'b0, pick_status(), FLAW_NONE);
      end else begin
        fl = flaw_t'($urandom_range(FLAW_XOR, FLAW_LEN0));
        send_frame(cmd_set[$urandom_range(0, 7)], $urandom_range(0, 4) == 0,
                   pick_status(), fl);
      end
      if ($urandom_range(0, 49) == 0) drain_results();
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
